@@ design/rcpfa_pkg.sv @@
// shared widths, command and status codes, and controller/datapath link types
package rcpfa_pkg;

  localparam int unsigned NumPagesDef = 32768;
  localparam int unsigned PageW       = 15;
  localparam int unsigned CountW      = 8;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned CmdW        = 2;

  localparam logic [CmdW-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CmdW-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CmdW-1:0] CMD_ADDREF  = 2'd2;
  localparam logic [CmdW-1:0] CMD_RESOLVE = 2'd3;

  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_NO_PAGES  = 3'd1;
  localparam logic [StatusW-1:0] ST_RANGE     = 3'd2;
  localparam logic [StatusW-1:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [StatusW-1:0] ST_SATURATED = 3'd4;

  localparam logic [CountW-1:0] CountMax = 8'd255;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
    logic wr2;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
    logic need_wr2;
  } dp_status_t;

endpackage

@@ design/rcpfa_ctrl.sv @@
// controller state machine: clearing pass, idle, execute, second count write
module rcpfa_ctrl
  import rcpfa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output ctrl_cmd_t  cmd_o,
  input  dp_status_t sts_i
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_WR2   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    cmd_o.clear  = (state_q == S_CLEAR);
    cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec   = (state_q == S_EXEC) && !sts_i.out_busy;
    cmd_o.wr2    = (state_q == S_WR2);
    in_ready_o   = (state_q == S_IDLE);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!sts_i.out_busy) state_d = sts_i.need_wr2 ? S_WR2 : S_IDLE;
      end
      S_WR2: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/rcpfa_dp.sv @@
// datapath: count memory, returned-page stack, watermark and result register
module rcpfa_dp
  import rcpfa_pkg::*;
#(
  parameter int unsigned NUM_PAGES = NumPagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         sts_o,
  input  logic               cfg_we_i,
  input  logic [PageW-1:0]   cfg_wdata_i,
  input  logic [CmdW-1:0]    command_i,
  input  logic [PageW-1:0]   page_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [PageW-1:0]   result_page_o,
  output logic               page_released_o,
  output logic               copy_needed_o,
  output logic [CountW-1:0]  count_after_o
);

  localparam int unsigned AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned DW = $clog2(NUM_PAGES + 1);
  localparam int unsigned EW = (AW > PageW) ? AW : PageW;

  logic [CountW-1:0] cnt_mem [NUM_PAGES];
  logic [PageW-1:0]  stk_mem [NUM_PAGES];

  logic [PageW-1:0]  fup_q;
  logic [CmdW-1:0]   cmd_q;
  logic [PageW-1:0]  page_q;
  logic [CountW-1:0] cnt_rd_q;
  logic [PageW-1:0]  stk_rd_q;
  logic [DW-1:0]     depth_q, depth_d;
  logic [DW-1:0]     wm_q, wm_d;
  logic [AW-1:0]     fresh_q;
  logic [AW-1:0]     clr_addr_q;

  logic              out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [PageW-1:0]  rpage_q;
  logic              released_q;
  logic              copy_q;
  logic [CountW-1:0] cnt_out_q;

  logic [EW-1:0]     page_in_ext, page_q_ext, take_ext;
  logic [DW-1:0]     depth_m1, wm_m1;
  logic              have_stk, have_wm, can_take, in_range;

  // exec decisions
  logic              ex_take, ex_push, ex_we, ex_wr2;
  logic [AW-1:0]     ex_waddr;
  logic [CountW-1:0] ex_wdata;
  logic [StatusW-1:0] ex_status;
  logic [PageW-1:0]  ex_rpage;
  logic              ex_released, ex_copy;
  logic [CountW-1:0] ex_cnt;

  // count memory write port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CountW-1:0] mem_wdata;

  assign page_in_ext = EW'(page_i);
  assign page_q_ext  = EW'(page_q);
  assign depth_m1    = depth_q - DW'(1);
  assign wm_m1       = wm_q - DW'(1);
  assign have_stk    = (depth_q != '0);
  assign have_wm     = (32'(wm_q) > 32'(fup_q));
  assign can_take    = have_stk || have_wm;
  assign take_ext    = have_stk ? EW'(stk_rd_q) : EW'(wm_m1[AW-1:0]);
  assign in_range    = (page_q >= fup_q) && (32'(page_q) < 32'(NUM_PAGES));

  always_comb begin
    ex_take     = 1'b0;
    ex_push     = 1'b0;
    ex_we       = 1'b0;
    ex_wr2      = 1'b0;
    ex_waddr    = page_q_ext[AW-1:0];
    ex_wdata    = '0;
    ex_status   = ST_OK;
    ex_rpage    = '0;
    ex_released = 1'b0;
    ex_copy     = 1'b0;
    ex_cnt      = '0;
    if (cmd_q == CMD_ALLOC) begin
      if (can_take) begin
        ex_take  = 1'b1;
        ex_we    = 1'b1;
        ex_waddr = take_ext[AW-1:0];
        ex_wdata = CountW'(1);
        ex_rpage = take_ext[PageW-1:0];
        ex_cnt   = CountW'(1);
      end else begin
        ex_status = ST_NO_PAGES;
      end
    end else if (!in_range) begin
      ex_status = ST_RANGE;
    end else if (cnt_rd_q == '0) begin
      ex_status = ST_NOT_ALLOC;
    end else begin
      ex_cnt = cnt_rd_q;
      unique case (cmd_q)
        CMD_RELEASE: begin
          ex_we    = 1'b1;
          ex_wdata = cnt_rd_q - CountW'(1);
          ex_cnt   = cnt_rd_q - CountW'(1);
          ex_rpage = page_q;
          if (cnt_rd_q == CountW'(1)) begin
            ex_released = 1'b1;
            ex_push     = (32'(depth_q) < 32'(NUM_PAGES));
          end
        end
        CMD_ADDREF: begin
          if (cnt_rd_q == CountMax) begin
            ex_status = ST_SATURATED;
          end else begin
            ex_we    = 1'b1;
            ex_wdata = cnt_rd_q + CountW'(1);
            ex_cnt   = cnt_rd_q + CountW'(1);
            ex_rpage = page_q;
          end
        end
        default: begin
          if (cnt_rd_q == CountW'(1)) begin
            ex_rpage = page_q;
          end else if (can_take) begin
            ex_take  = 1'b1;
            ex_we    = 1'b1;
            ex_wr2   = 1'b1;
            ex_wdata = cnt_rd_q - CountW'(1);
            ex_cnt   = cnt_rd_q - CountW'(1);
            ex_rpage = take_ext[PageW-1:0];
            ex_copy  = 1'b1;
          end else begin
            ex_status = ST_NO_PAGES;
          end
        end
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ex_waddr;
    mem_wdata = ex_wdata;
    if (cmd_i.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (cmd_i.wr2) begin
      mem_we    = 1'b1;
      mem_waddr = fresh_q;
      mem_wdata = CountW'(1);
    end else if (cmd_i.exec) begin
      mem_we = ex_we;
    end
  end

  always_comb begin
    depth_d = depth_q;
    wm_d    = wm_q;
    if (cmd_i.exec) begin
      if (ex_push) begin
        depth_d = depth_q + DW'(1);
      end else if (ex_take) begin
        if (have_stk) depth_d = depth_m1;
        else          wm_d    = wm_m1;
      end
    end
  end

  assign sts_o.clr_last = (clr_addr_q == AW'(NUM_PAGES - 1));
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign sts_o.need_wr2 = ex_wr2;

  // memories
  always_ff @(posedge clk_i) begin
    if (mem_we) cnt_mem[mem_waddr] <= mem_wdata;
    if (cmd_i.accept) cnt_rd_q <= cnt_mem[page_in_ext[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && ex_push) stk_mem[depth_q[AW-1:0]] <= page_q;
    if (cmd_i.accept) stk_rd_q <= stk_mem[depth_m1[AW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= command_i;
      page_q <= page_i;
    end
    if (cmd_i.exec) begin
      fresh_q    <= take_ext[AW-1:0];
      status_q   <= ex_status;
      rpage_q    <= ex_rpage;
      released_q <= ex_released;
      copy_q     <= ex_copy;
      cnt_out_q  <= ex_cnt;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fup_q       <= '0;
      depth_q     <= '0;
      wm_q        <= DW'(NUM_PAGES);
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) fup_q <= cfg_wdata_i;
      depth_q <= depth_d;
      wm_q    <= wm_d;
      if (cmd_i.clear) clr_addr_q <= clr_addr_q + AW'(1);
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_page_o   = rpage_q;
  assign page_released_o = released_q;
  assign copy_needed_o   = copy_q;
  assign count_after_o   = cnt_out_q;

endmodule

@@ design/refcounted_page_frame_allocator_top.sv @@
// top level of the reference-counted page frame allocator
// a transfer registers the command, page and memory reads; the execute state then loads the
// result register, waiting while the last result is held; a new item is taken only in idle,
// once the last has executed; the single-port count memory takes one read, then at most two
// writes per item, the second for a resolve handing out a fresh page; after reset a clearing
// pass zeroes the count memory with input ready low; configuration writes are taken during it
module refcounted_page_frame_allocator_top
  import rcpfa_pkg::*;
#(
  parameter int unsigned NUM_PAGES = NumPagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PageW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [PageW-1:0]   page_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [PageW-1:0]   result_page_o,
  output logic               page_released_o,
  output logic               copy_needed_o,
  output logic [CountW-1:0]  count_after_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  rcpfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  rcpfa_dp #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (command_i),
    .page_i          (page_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .result_page_o   (result_page_o),
    .page_released_o (page_released_o),
    .copy_needed_o   (copy_needed_o),
    .count_after_o   (count_after_o)
  );

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the reference-counted page frame allocator
`timescale 1ns / 100ps

module testbench;
  import rcpfa_pkg::*;

  localparam int unsigned NUM_PAGES = NumPagesDef;
  localparam int unsigned TopPage   = NUM_PAGES - 1;
  // the clearing pass after reset alone holds input ready low while it zeroes every count
  localparam int unsigned QuietLimit = 150000;
  localparam int unsigned PrintCap   = 40;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [PageW-1:0] pg;
  } frame_op_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PageW-1:0]   page;
    logic               released;
    logic               copy;
    logic [CountW-1:0]  count;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [PageW-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CmdW-1:0]    command = CMD_ALLOC;
  logic [PageW-1:0]   page = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [StatusW-1:0] status;
  logic [PageW-1:0]   result_page;
  logic               page_released;
  logic               copy_needed;
  logic [CountW-1:0]  count_after;

  // shadow of the allocator state
  bit [CountW-1:0]  ref_count [NUM_PAGES];
  logic [PageW-1:0] freed_stack [$];
  int unsigned      fresh_mark = NUM_PAGES;
  int unsigned      first_page = 0;

  frame_op_t     pending_ops [$];
  frame_result_t expected_results [$];
  logic [PageW-1:0] live_frames [$];
  frame_op_t     next_op;

  logic        in_acc = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          burst = 1'b0;
  int unsigned quiet = 0;
  int unsigned errors = 0;
  int unsigned ops_sent = 0;
  int unsigned results_seen = 0;
  int unsigned status_hits [8];

  refcounted_page_frame_allocator_top #(
    .NUM_PAGES(NUM_PAGES)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .page_i         (page),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .result_page_o  (result_page),
    .page_released_o(page_released),
    .copy_needed_o  (copy_needed),
    .count_after_o  (count_after)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit take_frame(output logic [PageW-1:0] pg);
    pg = '0;
    if (freed_stack.size() > 0) begin
      pg = freed_stack.pop_back();
    end else if (fresh_mark > first_page && fresh_mark > 0) begin
      fresh_mark--;
      pg = PageW'(fresh_mark);
    end else begin
      return 1'b0;
    end
    ref_count[pg] = CountW'(1);
    live_frames.push_back(pg);
    if (live_frames.size() > 48) void'(live_frames.pop_front());
    return 1'b1;
  endfunction

  function automatic frame_result_t predict_frame_op(logic [CmdW-1:0] cmd,
                                                     logic [PageW-1:0] pg);
    frame_result_t r;
    logic [PageW-1:0] fresh;
    int unsigned c;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      if (take_frame(fresh)) begin
        r.page  = fresh;
        r.count = CountW'(1);
      end else begin
        r.status = ST_NO_PAGES;
      end
    end else if (pg < first_page || int'(pg) >= NUM_PAGES) begin
      r.status = ST_RANGE;
    end else begin
      c = 32'(ref_count[pg]);
      r.count = CountW'(c);
      if (c == 0) begin
        r.status = ST_NOT_ALLOC;
      end else if (cmd == CMD_RELEASE) begin
        c--;
        ref_count[pg] = CountW'(c);
        r.count = CountW'(c);
        r.page  = pg;
        if (c == 0) begin
          freed_stack.push_back(pg);
          r.released = 1'b1;
        end
      end else if (cmd == CMD_ADDREF) begin
        if (c >= CountMax) begin
          r.status = ST_SATURATED;
        end else begin
          c++;
          ref_count[pg] = CountW'(c);
          r.count = CountW'(c);
          r.page  = pg;
        end
      end else begin
        if (c <= 1) begin
          r.page = pg;
        end else if (take_frame(fresh)) begin
          c--;
          ref_count[pg] = CountW'(c);
          r.count = CountW'(c);
          r.page  = fresh;
          r.copy  = 1'b1;
        end else begin
          r.status = ST_NO_PAGES;
        end
      end
    end
    return r;
  endfunction

  task automatic report(string msg);
    if (errors < PrintCap) $display("[%0t] ERROR: %s", $time, msg);
    errors++;
  endtask

  task automatic check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("result with nothing outstanding: status %0d page %0d",
                       status, result_page));
      return;
    end
    want = expected_results.pop_front();
    results_seen++;
    status_hits[want.status]++;
    if (status !== want.status)
      report($sformatf("result %0d status got %0d, expected %0d",
                       results_seen, status, want.status));
    if (result_page !== want.page)
      report($sformatf("result %0d result_page got %0d, expected %0d",
                       results_seen, result_page, want.page));
    if (page_released !== want.released)
      report($sformatf("result %0d page_released got %0b, expected %0b",
                       results_seen, page_released, want.released));
    if (copy_needed !== want.copy)
      report($sformatf("result %0d copy_needed got %0b, expected %0b",
                       results_seen, copy_needed, want.copy));
    if (count_after !== want.count)
      report($sformatf("result %0d count_after got %0d, expected %0d",
                       results_seen, count_after, want.count));
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_acc)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_ops.size() > 0) begin
        next_op = pending_ops.pop_front();
        command  <= next_op.cmd;
        page     <= next_op.pg;
        in_valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
        if (!burst && $urandom_range(0, 99) < 25) out_stall = pick_gap();
      end
    end
  end

  // monitor, prediction and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_frame_op(command, page));
        ops_sent++;
      end
      if (out_valid && out_ready) check_result();
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QuietLimit) begin
          $display("timeout: no transfer for %0d cycles", QuietLimit);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  task automatic push_op(logic [CmdW-1:0] cmd, int unsigned pg);
    frame_op_t op;
    op.cmd = cmd;
    op.pg  = PageW'(pg);
    while (pending_ops.size() >= 4) @(posedge clk);
    pending_ops.push_back(op);
  endtask

  task automatic settle();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_first_page(int unsigned v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= PageW'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    first_page = v;
  endtask

  task automatic random_ops(int n);
    int r;
    int unsigned pg;
    logic [CmdW-1:0] cmd;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 30) cmd = CMD_ALLOC;
      else if (r < 60) cmd = CMD_RELEASE;
      else if (r < 80) cmd = CMD_ADDREF;
      else cmd = CMD_RESOLVE;
      r = $urandom_range(0, 99);
      if (r < 75 && live_frames.size() > 0) begin
        pg = 32'(live_frames[$urandom_range(0, live_frames.size() - 1)]);
      end else if (r < 85) begin
        pg = $urandom_range(first_page, TopPage);
      end else if (r < 92) begin
        case ($urandom_range(0, 3))
          0: pg = first_page;
          1: pg = (first_page == 0) ? 0 : first_page - 1;
          2: pg = TopPage;
          default: pg = 0;
        endcase
      end else begin
        pg = $urandom_range(0, TopPage);
      end
      push_op(cmd, pg);
    end
    burst = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single usable page
    write_first_page(TopPage);
    push_op(CMD_RELEASE, TopPage);
    push_op(CMD_ADDREF, 0);
    push_op(CMD_RESOLVE, 100);
    push_op(CMD_ALLOC, 12345);
    push_op(CMD_ALLOC, TopPage);
    push_op(CMD_RESOLVE, TopPage);
    push_op(CMD_ADDREF, TopPage);
    push_op(CMD_RESOLVE, TopPage);
    push_op(CMD_RELEASE, TopPage);
    push_op(CMD_RELEASE, TopPage);
    push_op(CMD_RELEASE, TopPage);
    push_op(CMD_ADDREF, TopPage);
    push_op(CMD_RESOLVE, TopPage);
    push_op(CMD_ALLOC, 0);
    push_op(CMD_RELEASE, 0);
    push_op(CMD_ADDREF, TopPage);
    settle();

    // small pool just below the top
    write_first_page(TopPage - 7);
    push_op(CMD_RESOLVE, TopPage);
    push_op(CMD_RELEASE, TopPage - 1);
    push_op(CMD_RESOLVE, TopPage - 8);
    // drive one count up to saturation, then back down
    for (int i = 0; i < 256; i++) push_op(CMD_ADDREF, TopPage);
    push_op(CMD_RESOLVE, TopPage);
    for (int i = 0; i < 3; i++) push_op(CMD_RELEASE, TopPage);
    random_ops(150);
    settle();

    write_first_page(0);
    random_ops(250);
    settle();

    write_first_page(NUM_PAGES / 2);
    random_ops(200);
    settle();

    // raised to or above the watermark, so only returned pages come back
    write_first_page(TopPage);
    random_ops(80);
    settle();

    $display("%0d frame requests driven, %0d results checked over five page floors",
             ops_sent, results_seen);
    $display("outcomes: ok %0d, no pages %0d, range %0d, not allocated %0d, saturated %0d",
             status_hits[ST_OK], status_hits[ST_NO_PAGES], status_hits[ST_RANGE],
             status_hits[ST_NOT_ALLOC], status_hits[ST_SATURATED]);
    if (expected_results.size() > 0)
      report($sformatf("%0d results never arrived", expected_results.size()));
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
